/* rtl/ese_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_pkg: shared types and constants of the encoder speed estimator
// Field widths, register indexes, register reset values and the
// configuration bundle that travels from the register file to the datapath.
// ----------------------------------------------------------------------------
package ese_pkg;

  // Encoder counter width used for position masking and the stored sample.
  localparam int PosW     = 16;
  localparam int InPosW   = 16;
  localparam int CprW     = 17;
  localparam int GainW    = 32;
  localparam int GateW    = 31;
  localparam int AlphaW   = 17;
  localparam int SpeedW   = 32;

  // Tick difference: two positions and the modulus, plus sign and carry.
  localparam int DiffW    = ((PosW > CprW) ? PosW : CprW) + 2;

  // Shared multiplier: signed operands wide enough for a 32-bit unsigned
  // gain and a 33-bit speed difference.
  localparam int MulW     = 33;
  localparam int ProdW    = 2 * MulW;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgCountsPerRev  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSpeedGain     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGateHalfwidth = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSmoothAlpha   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgReverseDir    = 3'd4;

  localparam logic [CprW-1:0]   RstCountsPerRev  = 17'd4096;
  localparam logic [GainW-1:0]  RstSpeedGain     = 32'd65536;
  localparam logic [GateW-1:0]  RstGateHalfwidth = 31'h7FFF_FFFF;
  localparam logic [AlphaW-1:0] RstSmoothAlpha   = 17'd65536;

  // Q1.16 unity weight.
  localparam logic [AlphaW-1:0] AlphaOne         = 17'd65536;

  typedef struct packed {
    logic [CprW-1:0]   counts_per_rev;
    logic [GainW-1:0]  speed_gain;
    logic [GateW-1:0]  gate_halfwidth;
    logic [AlphaW-1:0] smoothing_alpha;
    logic              reverse_dir;
  } cfg_t;

endpackage

/* rtl/ese_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_if: valid/ready channels of the encoder speed estimator
// One channel for counter samples, one for filtered speed results.
// ----------------------------------------------------------------------------
interface ese_smp_if;
  logic                      valid;
  logic                      ready;
  logic [ese_pkg::InPosW-1:0] position;
  logic                      count_down;

  modport source (output valid, position, count_down, input ready);
  modport sink   (input valid, position, count_down, output ready);
endinterface

interface ese_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [ese_pkg::SpeedW-1:0] speed;
  logic                             accepted;

  modport source (output valid, speed, accepted, input ready);
  modport sink   (input valid, speed, accepted, output ready);
endinterface

/* rtl/encoder_speed_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_estimator: quadrature encoder speed with gated EMA filter
// Steps: Scale, Gate, Blend, Sum, Out; a gated-out sample skips Blend and Sum.
// One sample at a time, as the sequencer reuses the single 33x33 multiplier
// for the gain scale and then the average; ready returns in Idle only.
// Reset: asynchronous active low; clears stored position and speed, loads
// register defaults (4096, 65536, 2^31-1, 65536, 0).
// ----------------------------------------------------------------------------
module encoder_speed_estimator import ese_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  ese_smp_if.sink             smp_i,
  ese_res_if.source           res_o,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_idx_i,
  input  logic [CfgDataW-1:0] wr_data_i
);

  // Sequencer codes.
  localparam logic [2:0] SIdle  = 3'd0;  // wait for a sample transaction
  localparam logic [2:0] SScale = 3'd1;  // multiply tick difference by gain
  localparam logic [2:0] SGate  = 3'd2;  // saturate, sign, gate compare
  localparam logic [2:0] SBlend = 3'd3;  // multiply speed delta by alpha
  localparam logic [2:0] SSum   = 3'd4;  // add, round and store the average
  localparam logic [2:0] SOut   = 3'd5;  // hand the result to the output register

  cfg_t cfg;

  logic [2:0]               state_q, state_d;
  logic [PosW-1:0]          last_pos_q;
  logic signed [SpeedW-1:0] filt_q;
  logic signed [DiffW-1:0]  diff_q;
  logic signed [MulW-1:0]   delta_q;
  logic                     ok_q;
  logic                     out_valid_q;
  logic signed [SpeedW-1:0] out_speed_q;
  logic                     out_acc_q;

  logic                     smp_fire;
  logic [PosW-1:0]          pos;
  logic signed [DiffW-1:0]  p_ext, q_ext, n_ext, diff_d;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  prod;
  logic [AlphaW-1:0]        alpha_sat;

  logic                     prod_fits;
  logic signed [SpeedW-1:0] scaled, fresh;
  logic signed [MulW-1:0]   gap;
  logic [MulW-1:0]          gap_abs;
  logic                     ok_d;
  logic signed [ProdW-1:0]  blend_sum;
  logic                     out_free;

  ese_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en_i),
    .wr_idx_i  (wr_idx_i),
    .wr_data_i (wr_data_i),
    .cfg_o     (cfg)
  );

  // --------------------------------------------------------------------------
  // Tick difference with single wrap correction in the counting direction.
  // A zero modulus makes the correction add or subtract nothing.
  // --------------------------------------------------------------------------
  assign smp_fire = smp_i.valid && smp_i.ready;
  assign pos      = smp_i.position[PosW-1:0];
  assign p_ext    = DiffW'(pos);
  assign q_ext    = DiffW'(last_pos_q);
  assign n_ext    = DiffW'(cfg.counts_per_rev);

  always_comb begin
    if (smp_i.count_down) begin
      diff_d = (p_ext > q_ext) ? (p_ext - n_ext - q_ext) : (p_ext - q_ext);
    end else begin
      diff_d = (p_ext < q_ext) ? (n_ext + p_ext - q_ext) : (p_ext - q_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: gain scale first, then the moving-average weight.
  // Alpha above unity acts as unity.
  // --------------------------------------------------------------------------
  assign alpha_sat = (cfg.smoothing_alpha > AlphaOne) ? AlphaOne : cfg.smoothing_alpha;

  always_comb begin
    if (state_q == SScale) begin
      mul_a = MulW'(diff_q);
      mul_b = $signed({1'b0, cfg.speed_gain});
    end else begin
      mul_a = delta_q;
      mul_b = $signed(MulW'(alpha_sat));
    end
  end

  ese_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // --------------------------------------------------------------------------
  // Gate stage: saturate the scaled product to 32 bits, apply reverse with
  // saturation of the most negative value, then test |fresh - stored| < gate.
  // --------------------------------------------------------------------------
  assign prod_fits = (&prod[ProdW-1:SpeedW-1]) || ~(|prod[ProdW-1:SpeedW-1]);

  always_comb begin
    if (prod_fits) begin
      scaled = prod[SpeedW-1:0];
    end else if (prod[ProdW-1]) begin
      scaled = {1'b1, {(SpeedW-1){1'b0}}};
    end else begin
      scaled = {1'b0, {(SpeedW-1){1'b1}}};
    end
    if (!cfg.reverse_dir) begin
      fresh = scaled;
    end else if (scaled == {1'b1, {(SpeedW-1){1'b0}}}) begin
      fresh = {1'b0, {(SpeedW-1){1'b1}}};
    end else begin
      fresh = -scaled;
    end
  end

  assign gap     = MulW'(fresh) - MulW'(filt_q);
  assign gap_abs = gap[MulW-1] ? MulW'(-gap) : MulW'(gap);
  assign ok_d    = gap_abs < MulW'(cfg.gate_halfwidth);

  // Average: stored*2^16 + (fresh - stored)*alpha + half, floor by 2^16.
  assign blend_sum = ProdW'({filt_q, 16'h0000}) + prod + ProdW'(32768);

  // Output register frees when empty or when its transaction completes.
  assign out_free = !out_valid_q || res_o.ready;

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (smp_fire) state_d = SScale;
      SScale:  state_d = SGate;
      SGate:   state_d = ok_d ? SBlend : SOut;
      SBlend:  state_d = SSum;
      SSum:    state_d = SOut;
      SOut:    if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      last_pos_q  <= '0;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Replace the stored sample on every transaction.
      if (smp_fire) begin
        last_pos_q <= pos;
      end
      if (state_q == SSum) begin
        filt_q <= blend_sum[SpeedW+15:16];
      end
      if (state_q == SOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (smp_fire) begin
      diff_q <= diff_d;
    end
    if (state_q == SGate) begin
      delta_q <= gap;
      ok_q    <= ok_d;
    end
    if (state_q == SOut && out_free) begin
      out_speed_q <= filt_q;
      out_acc_q   <= ok_q;
    end
  end

  assign smp_i.ready    = (state_q == SIdle);
  assign res_o.valid    = out_valid_q;
  assign res_o.speed    = out_speed_q;
  assign res_o.accepted = out_acc_q;

endmodule

/* rtl/ese_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_mul: shared signed multiplier
// One signed multiply per cycle with the product registered.
// ----------------------------------------------------------------------------
module ese_mul import ese_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] p_o
);

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

/* rtl/ese_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_cfg: configuration register file
// Write-only registers, truncated to their field widths on write.
// ----------------------------------------------------------------------------
module ese_cfg import ese_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_idx_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        CfgCountsPerRev:  cfg_d.counts_per_rev  = wr_data_i[CprW-1:0];
        CfgSpeedGain:     cfg_d.speed_gain      = wr_data_i[GainW-1:0];
        CfgGateHalfwidth: cfg_d.gate_halfwidth  = wr_data_i[GateW-1:0];
        CfgSmoothAlpha:   cfg_d.smoothing_alpha = wr_data_i[AlphaW-1:0];
        CfgReverseDir:    cfg_d.reverse_dir     = wr_data_i[0];
        default:          cfg_d = cfg_q;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counts_per_rev  <= RstCountsPerRev;
      cfg_q.speed_gain      <= RstSpeedGain;
      cfg_q.gate_halfwidth  <= RstGateHalfwidth;
      cfg_q.smoothing_alpha <= RstSmoothAlpha;
      cfg_q.reverse_dir     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* tb/encoder_speed_estimator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_estimator_test: self-checking bench for the speed estimator
// Streams counter samples into the block, predicts every filtered speed and
// gate decision in the bench, and compares each result transaction field by
// field. Covers wrap correction, saturation, gating, rounding, back-pressure
// and randomized encoder walks under several register settings.
// ----------------------------------------------------------------------------
module encoder_speed_estimator_test;
  import ese_pkg::*;

  // No-transaction cycles tolerated before the run is declared hung. The
  // longest legal quiet stretch is the deliberate receiver hold-off below.
  localparam int WatchLimit  = 4000;
  localparam int HoldCycles  = 400;
  localparam int SettleDelay = 8;

  typedef struct {
    logic signed [SpeedW-1:0] speed;
    logic                     accepted;
  } speed_result_t;

  logic clk_i;
  logic rst_ni;
  logic                wr_en;
  logic [CfgIdxW-1:0]  wr_idx;
  logic [CfgDataW-1:0] wr_data;

  ese_smp_if smp_ch ();
  ese_res_if res_ch ();

  encoder_speed_estimator DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .smp_i    (smp_ch),
    .res_o    (res_ch),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data)
  );

  // Bench copy of the block state and registers.
  cfg_t                     cfg_copy;
  logic [PosW-1:0]          last_pos_copy;
  logic signed [SpeedW-1:0] speed_copy;

  // Expected results in transaction order.
  speed_result_t speed_q[$];

  int mismatch_cnt;
  int quiet_cycles;
  int snd_idle_pct;
  int rcv_idle_pct;
  int res_hold_req;
  int res_hold_left;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: wrap-corrected tick difference, saturating gain scale,
  // optional sign flip, exclusive gate and rounded moving average.
  // --------------------------------------------------------------------------
  function automatic speed_result_t predict_speed(logic [InPosW-1:0] pos_in, logic down);
    longint        p, q, n, ticks, prod, gap, sum, wgt;
    logic signed [SpeedW-1:0] fresh;
    speed_result_t r;
    p = longint'(pos_in[PosW-1:0]);
    q = longint'(last_pos_copy);
    n = longint'(cfg_copy.counts_per_rev);
    // Assume one wrap in the counting direction; equal positions never wrap.
    if (down) ticks = (p > q) ? (p - n - q) : (p - q);
    else      ticks = (p < q) ? (n + p - q) : (p - q);
    // The difference stays within 18 bits, so the 64-bit product is exact.
    prod = ticks * longint'(cfg_copy.speed_gain);
    if (prod > 64'sd2147483647)       fresh = 32'sh7FFF_FFFF;
    else if (prod < -64'sd2147483648) fresh = 32'sh8000_0000;
    else                              fresh = prod[SpeedW-1:0];
    if (cfg_copy.reverse_dir)
      fresh = (fresh == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -fresh;
    gap = longint'(fresh) - longint'(speed_copy);
    if (gap < 0) gap = -gap;
    r.accepted = (gap < longint'(cfg_copy.gate_halfwidth));
    if (r.accepted) begin
      // Clamp alpha to unity; the arithmetic shift floors, so the added half
      // rounds ties toward plus infinity.
      wgt = (cfg_copy.smoothing_alpha > AlphaOne) ? 65536 : longint'(cfg_copy.smoothing_alpha);
      sum = longint'(fresh) * wgt + longint'(speed_copy) * (65536 - wgt) + 32768;
      speed_copy = SpeedW'(sum >>> 16);
    end
    last_pos_copy = pos_in[PosW-1:0];
    r.speed = speed_copy;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Register writes, one at a time, mirrored into the bench copy.
  // Call only while the block is idle.
  // --------------------------------------------------------------------------
  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    wr_en   = 1'b1;
    wr_idx  = idx;
    wr_data = value;
    case (idx)
      CfgCountsPerRev:  cfg_copy.counts_per_rev  = value[CprW-1:0];
      CfgSpeedGain:     cfg_copy.speed_gain      = value[GainW-1:0];
      CfgGateHalfwidth: cfg_copy.gate_halfwidth  = value[GateW-1:0];
      CfgSmoothAlpha:   cfg_copy.smoothing_alpha = value[AlphaW-1:0];
      CfgReverseDir:    cfg_copy.reverse_dir     = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    wr_en = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Offer one sample. Valid stays high on return so that back-to-back
  // samples need no gap; settle_idle lowers it when the stream pauses.
  // --------------------------------------------------------------------------
  task automatic offer_sample(logic [InPosW-1:0] pos, logic down);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      smp_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    smp_ch.valid      = 1'b1;
    smp_ch.position   = pos;
    smp_ch.count_down = down;
    do @(posedge clk_i); while (!smp_ch.ready);
    speed_q.push_back(predict_speed(pos, down));
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic settle_idle();
    @(negedge clk_i);
    smp_ch.valid = 1'b0;
    while (speed_q.size() != 0) @(posedge clk_i);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  task automatic set_idling(int snd_pct, int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a long hold-off when one is requested.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (res_hold_req > 0) begin
      res_hold_left = res_hold_req;
      res_hold_req  = 0;
    end
    if (res_hold_left > 0) begin
      res_ch.ready  = 1'b0;
      res_hold_left = res_hold_left - 1;
    end else begin
      res_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: pop the oldest expectation on every result transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    speed_result_t exp_r;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (speed_q.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10)
          $display("%0t: result with nothing pending: speed %0d accepted %0b",
                   $realtime, res_ch.speed, res_ch.accepted);
      end else begin
        exp_r = speed_q.pop_front();
        if (res_ch.speed !== exp_r.speed || res_ch.accepted !== exp_r.accepted) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("%0t: mismatch: speed exp %0d got %0d, accepted exp %0b got %0b",
                     $realtime, exp_r.speed, res_ch.speed, exp_r.accepted,
                     res_ch.accepted);
        end
      end
    end
  end

  // Watchdog: count cycles without any transaction on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("encoder_speed_estimator verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed cases: wraps both ways, equal and out-of-range positions, zero
  // modulus, gain saturation and its negation, closed gate, alpha extremes
  // and rounding ties on both signs.
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    // Reset registers: modulus 4096, unity gain, open gate, alpha one.
    offer_sample(16'd0, 1'b0);       // no movement
    offer_sample(16'd100, 1'b0);     // plain up step
    offer_sample(16'd50, 1'b0);      // up with wrap
    offer_sample(16'd50, 1'b1);      // equal positions, no wrap
    offer_sample(16'd60, 1'b1);      // down with wrap
    offer_sample(16'd10, 1'b1);      // plain down step
    offer_sample(16'hFFFF, 1'b0);    // position above the modulus
    offer_sample(16'd0, 1'b1);       // plain down from the top
    offer_sample(16'hFFFF, 1'b1);    // down wrap from zero
    settle_idle();

    // Zero modulus with a huge gain: saturate both ways, then negate.
    set_reg(CfgCountsPerRev, 32'd0);
    set_reg(CfgSpeedGain, 32'hFFFF_FFFF);
    set_reg(CfgReverseDir, 32'd1);
    set_reg(CfgGateHalfwidth, 32'h7FFF_FFFF);
    offer_sample(16'd0, 1'b0);       // saturates low, negation clips high
    offer_sample(16'd5, 1'b1);       // saturates high
    settle_idle();

    // Closed gate rejects everything.
    set_reg(CfgCountsPerRev, 32'd65536);
    set_reg(CfgSpeedGain, 32'd1);
    set_reg(CfgReverseDir, 32'd0);
    set_reg(CfgGateHalfwidth, 32'd0);
    offer_sample(16'd1, 1'b0);
    offer_sample(16'd0, 1'b1);
    settle_idle();

    // Alpha zero holds, alpha above one acts as one, half-alpha ties.
    set_reg(CfgGateHalfwidth, 32'hFFFF_FFFF);
    set_reg(CfgSmoothAlpha, 32'd0);
    offer_sample(16'd3, 1'b0);
    settle_idle();
    set_reg(CfgSmoothAlpha, 32'h0001_FFFF);
    offer_sample(16'd7, 1'b0);
    settle_idle();
    set_reg(CfgSmoothAlpha, 32'd32768);
    offer_sample(16'd8, 1'b0);       // positive tie rounds up
    offer_sample(16'd7, 1'b1);
    offer_sample(16'd6, 1'b1);
    offer_sample(16'd5, 1'b1);       // negative tie rounds toward zero
    settle_idle();

    // Zero gain yields zero speed.
    set_reg(CfgSpeedGain, 32'd0);
    offer_sample(16'd1000, 1'b0);
    settle_idle();

    // Leave a moderate setting for the pressure test.
    set_reg(CfgCountsPerRev, 32'd4096);
    set_reg(CfgSpeedGain, 32'd65536);
    set_reg(CfgSmoothAlpha, 32'd16384);
  endtask

  // --------------------------------------------------------------------------
  // Back-pressure: hold the result side long enough that the block stalls
  // its input, then pause the sender until all results are back.
  // --------------------------------------------------------------------------
  task automatic test_backpressure();
    int k;
    set_idling(0, 0);
    res_hold_req = HoldCycles;
    for (k = 0; k < 40; k++)
      offer_sample(InPosW'((k * 37) % 4096), 1'b0);
    settle_idle();
    for (k = 0; k < 20; k++)
      offer_sample(InPosW'(4095 - (k * 53) % 4096), 1'b1);
    settle_idle();
  endtask

  // --------------------------------------------------------------------------
  // Random encoder walks. Each round loads a random register set, then
  // streams mostly consistent counter samples with some direction errors
  // and random noise.
  // --------------------------------------------------------------------------
  task automatic test_random_tracking(int snd_pct, int rcv_pct, int rounds, int per_round);
    int          rd, k, walk_mod, walk_pos, max_step, step, pick;
    logic        dir;
    logic [31:0] gain_v;
    longint      gate_v;
    set_idling(snd_pct, rcv_pct);
    for (rd = 0; rd < rounds; rd++) begin
      settle_idle();
      case ($urandom_range(9))
        0:       set_reg(CfgCountsPerRev, 32'd0);
        1:       set_reg(CfgCountsPerRev, 32'd1);
        2:       set_reg(CfgCountsPerRev, 32'd65536);
        default: set_reg(CfgCountsPerRev, $urandom_range(2, 65536));
      endcase
      case ($urandom_range(7))
        0:       gain_v = 32'd0;
        1:       gain_v = 32'hFFFF_FFFF;
        2:       gain_v = $urandom;
        default: gain_v = $urandom_range(1, 400000);
      endcase
      set_reg(CfgSpeedGain, gain_v);
      max_step = $urandom_range(1, 64);
      // Size the gate near typical jumps so both outcomes show up.
      case ($urandom_range(7))
        0:       gate_v = 0;
        1:       gate_v = 64'h7FFF_FFFF;
        2:       gate_v = longint'($urandom);
        default: gate_v = longint'(gain_v) * $urandom_range(1, 2 * max_step) / 2;
      endcase
      if (gate_v > 64'h7FFF_FFFF) gate_v = 64'h7FFF_FFFF;
      set_reg(CfgGateHalfwidth, gate_v[31:0]);
      case ($urandom_range(7))
        0:       set_reg(CfgSmoothAlpha, 32'd0);
        1:       set_reg(CfgSmoothAlpha, 32'd65536);
        2:       set_reg(CfgSmoothAlpha, $urandom_range(65537, 131071));
        default: set_reg(CfgSmoothAlpha, $urandom_range(1, 65535));
      endcase
      set_reg(CfgReverseDir, $urandom_range(1));

      walk_mod = (cfg_copy.counts_per_rev == 0) ? 65536 : int'(cfg_copy.counts_per_rev);
      walk_pos = $urandom_range(0, walk_mod - 1);
      dir      = 1'($urandom_range(1));
      for (k = 0; k < per_round; k++) begin
        pick = $urandom_range(99);
        if (pick < 3) dir = !dir;
        step = $urandom_range(0, max_step) % walk_mod;
        if (pick < 85) begin
          // Advance the counter; now and then flag the wrong direction.
          if (dir) walk_pos = (walk_pos + walk_mod - step) % walk_mod;
          else     walk_pos = (walk_pos + step) % walk_mod;
          offer_sample(InPosW'(walk_pos), (pick < 75) ? dir : !dir);
        end else begin
          offer_sample(InPosW'($urandom_range(0, 65535)), 1'($urandom_range(1)));
        end
      end
    end
    settle_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed, pressure, then random in three idle mixes.
  // --------------------------------------------------------------------------
  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    wr_en             = 1'b0;
    wr_idx            = CfgCountsPerRev;
    wr_data           = '0;
    smp_ch.valid      = 1'b0;
    smp_ch.position   = '0;
    smp_ch.count_down = 1'b0;
    res_ch.ready      = 1'b0;
    mismatch_cnt      = 0;
    quiet_cycles      = 0;
    res_hold_req      = 0;
    res_hold_left     = 0;
    cfg_copy.counts_per_rev  = RstCountsPerRev;
    cfg_copy.speed_gain      = RstSpeedGain;
    cfg_copy.gate_halfwidth  = RstGateHalfwidth;
    cfg_copy.smoothing_alpha = RstSmoothAlpha;
    cfg_copy.reverse_dir     = 1'b0;
    last_pos_copy = '0;
    speed_copy    = '0;
    set_idling(11, 69);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_backpressure();
    test_random_tracking(11, 69, 5, 100);
    test_random_tracking(69, 11, 5, 100);
    test_random_tracking(0, 0, 5, 100);

    // Drain the last results and give the block time to show any extras.
    settle_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && speed_q.size() == 0) begin
      $display("encoder_speed_estimator verification clean");
    end else begin
      $display("encoder_speed_estimator verification failed");
    end
    $finish;
  end

endmodule
